FILE: rtl/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types, constants and table builders for the rastrigin metropolis step
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int COORD_W = 16;
  localparam int VALUE_W = 22;
  localparam int STEP_W  = 12;
  localparam int INV_W   = 16;
  localparam int UNI_W   = 16;
  localparam int COS_W   = 14;
  localparam int PROB_W  = 17;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam int COS_TABLE_BITS_DEF = 10;
  localparam int EXP_TABLE_BITS_DEF = 10;

  localparam logic signed [COORD_W-1:0] RANGE_LOW_RESET  = -16'sd20972;
  localparam logic signed [COORD_W-1:0] RANGE_HIGH_RESET = 16'sd20972;
  localparam logic [STEP_W-1:0]         STEP_RESET       = 12'd410;
  localparam logic [INV_W-1:0]          INV_TEMP_RESET   = 16'd5120;
  localparam logic signed [COORD_W-1:0] SECOND_LOW       = -16'sd20972;
  localparam logic signed [COORD_W-1:0] SECOND_HIGH      = 16'sd20972;
  localparam logic [VALUE_W-1:0]        LOW_VALUE_RESET  = 22'd4096000;
  localparam logic [VALUE_W-1:0]        VALUE_MAX        = 22'd4194303;
  localparam logic [PROB_W-1:0]         PROB_ONE         = 17'd65536;

  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [63:0] EXPM1_Q30  = 64'd395007542;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  typedef enum logic [IDX_W-1:0] {
    REG_RANGE_LOW  = 2'd0,
    REG_RANGE_HIGH = 2'd1,
    REG_STEP_SIZE  = 2'd2,
    REG_INV_TEMP   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_STEP    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  localparam logic [1:0] MOVE_MINUS = 2'd0;
  localparam logic [1:0] MOVE_PLUS  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_COSY, S_CLAMP, S_MUL, S_EXP, S_DEC, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic sq_x;
    logic sq_y;
    logic cos_y;
    logic clamp;
    logic mul;
    logic dec;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic bad;
    logic slot_free;
  } status_t;

  function automatic logic [63:0] cos_div(input int k, input logic [63:0] v);
    case (k)
      1:       return v / 64'd2;
      2:       return v / 64'd12;
      3:       return v / 64'd30;
      4:       return v / 64'd56;
      5:       return v / 64'd90;
      6:       return v / 64'd132;
      default: return v / 64'd182;
    endcase
  endfunction

  function automatic logic [63:0] sin_div(input int k, input logic [63:0] v);
    case (k)
      1:       return v / 64'd6;
      2:       return v / 64'd20;
      3:       return v / 64'd42;
      4:       return v / 64'd72;
      5:       return v / 64'd110;
      default: return v / 64'd156;
    endcase
  endfunction

  function automatic logic [63:0] exp_div(input int k, input logic [63:0] v);
    case (k)
      1:       return v;
      2:       return v / 64'd2;
      3:       return v / 64'd3;
      4:       return v / 64'd4;
      5:       return v / 64'd5;
      6:       return v / 64'd6;
      7:       return v / 64'd7;
      8:       return v / 64'd8;
      9:       return v / 64'd9;
      10:      return v / 64'd10;
      11:      return v / 64'd11;
      default: return v / 64'd12;
    endcase
  endfunction

  function automatic longint q30_to_q12(input longint v);
    longint r;
    r = v + (longint'(1) <<< 17);
    if (r < 0) r = 0;
    r = r >>> 18;
    if (r > 4096) r = 4096;
    return r;
  endfunction

  function automatic logic signed [COS_W-1:0] cos_entry(input int idx, input int bits);
    logic [63:0] ph;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    longint c;
    longint s;
    longint cq;
    longint sq;
    ph = (64'(idx) << (16 - bits)) & 64'hFFFF;
    a  = ((ph & 64'h3FFF) * HALFPI_Q30) >> 14;
    a2 = (a * a) >> 30;
    t  = ONE_Q30;
    c  = longint'(t);
    for (int k = 1; k <= 7; k++) begin
      t = cos_div(k, (t * a2) >> 30);
      c = k[0] ? c - longint'(t) : c + longint'(t);
    end
    t = a;
    s = longint'(t);
    for (int k = 1; k <= 6; k++) begin
      t = sin_div(k, (t * a2) >> 30);
      s = k[0] ? s - longint'(t) : s + longint'(t);
    end
    cq = q30_to_q12(c);
    sq = q30_to_q12(s);
    case (ph[15:14])
      2'd0:    return COS_W'(cq);
      2'd1:    return COS_W'(-sq);
      2'd2:    return COS_W'(-cq);
      default: return COS_W'(sq);
    endcase
  endfunction

  function automatic logic [PROB_W-1:0] exp_entry(input int idx, input int bits);
    logic [63:0] w;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] r;
    longint sum;
    w   = 64'(idx) << (34 - bits);
    n   = w >> 30;
    f   = w & (ONE_Q30 - 64'd1);
    t   = ONE_Q30;
    sum = longint'(t);
    for (int k = 1; k <= 12; k++) begin
      t   = exp_div(k, (t * f) >> 30);
      sum = k[0] ? sum - longint'(t) : sum + longint'(t);
    end
    r = (sum < 0) ? 64'd0 : 64'(sum);
    for (int i = 0; i < 16; i++) begin
      if (64'(i) < n) r = (r * EXPM1_Q30) >> 30;
    end
    return PROB_W'((r + 64'd8192) >> 14);
  endfunction

  function automatic int cos_index(input longint x, input int bits);
    return int'(((x & 64'hFFF) << 4) >> (16 - bits));
  endfunction

  function automatic logic [VALUE_W-1:0] objective_init(input longint x, input longint y,
                                                        input int bits);
    longint v;
    v = 81920;
    v = v + ((x * x + 2048) >>> 12);
    v = v + ((y * y + 2048) >>> 12);
    v = v - 10 * longint'(cos_entry(cos_index(x, bits), bits));
    v = v - 10 * longint'(cos_entry(cos_index(y, bits), bits));
    if (v < 0) v = 0;
    if (v > 4194303) v = 4194303;
    return VALUE_W'(v);
  endfunction

endpackage

FILE: rtl/rms_in_if.sv
// ----------------------------------------------------------------------------
// rms_in_if
// Input channel: one step request per transfer
// ----------------------------------------------------------------------------
interface rms_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] move_first;
  logic [1:0] move_second;
  logic [rms_pkg::UNI_W-1:0] uniform;

  modport source (output valid, operation, move_first, move_second, uniform, input ready);
  modport sink   (input valid, operation, move_first, move_second, uniform, output ready);
endinterface

FILE: rtl/rms_out_if.sv
// ----------------------------------------------------------------------------
// rms_out_if
// Output channel: one step result per transfer
// ----------------------------------------------------------------------------
interface rms_out_if;
  logic valid;
  logic ready;
  logic accepted;
  logic proposal_invalid;
  logic signed [rms_pkg::COORD_W-1:0] point_first;
  logic signed [rms_pkg::COORD_W-1:0] point_second;
  logic        [rms_pkg::VALUE_W-1:0] point_value;
  logic        [rms_pkg::VALUE_W-1:0] best_value;
  logic signed [rms_pkg::COORD_W-1:0] best_first;
  logic signed [rms_pkg::COORD_W-1:0] best_second;

  modport source (output valid, accepted, proposal_invalid, point_first, point_second,
                  point_value, best_value, best_first, best_second, input ready);
  modport sink   (input valid, accepted, proposal_invalid, point_first, point_second,
                  point_value, best_value, best_first, best_second, output ready);
endinterface

FILE: rtl/rms_ctrl.sv
// ----------------------------------------------------------------------------
// rms_ctrl
// Sequencer for one metropolis step over the shared datapath
// ----------------------------------------------------------------------------
module rms_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rms_pkg::status_t status,
  output rms_pkg::cmd_t    cmd
);

  rms_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rms_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      rms_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = rms_pkg::S_SQX;
        end
      end
      rms_pkg::S_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = (status.bad && !status.restart) ? rms_pkg::S_DONE : rms_pkg::S_SQY;
      end
      rms_pkg::S_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = rms_pkg::S_COSY;
      end
      rms_pkg::S_COSY: begin
        cmd.cos_y  = 1'b1;
        state_next = rms_pkg::S_CLAMP;
      end
      rms_pkg::S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = status.restart ? rms_pkg::S_DONE : rms_pkg::S_MUL;
      end
      rms_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = rms_pkg::S_EXP;
      end
      rms_pkg::S_EXP: begin
        state_next = rms_pkg::S_DEC;
      end
      rms_pkg::S_DEC: begin
        cmd.dec    = 1'b1;
        state_next = rms_pkg::S_DONE;
      end
      rms_pkg::S_DONE: begin
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          state_next = rms_pkg::S_IDLE;
        end
      end
      default: state_next = rms_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: rtl/rms_datapath.sv
// ----------------------------------------------------------------------------
// rms_datapath
// Point state, objective evaluation, acceptance test and result register
// ----------------------------------------------------------------------------
module rms_datapath #(
  parameter int COS_TABLE_BITS = rms_pkg::COS_TABLE_BITS_DEF,
  parameter int EXP_TABLE_BITS = rms_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rms_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rms_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_operation,
  input  logic [1:0]                        in_move_first,
  input  logic [1:0]                        in_move_second,
  input  logic [rms_pkg::UNI_W-1:0]         in_uniform,
  input  rms_pkg::cmd_t                     cmd,
  output rms_pkg::status_t                  status,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic                              out_invalid,
  output logic signed [rms_pkg::COORD_W-1:0] out_point_first,
  output logic signed [rms_pkg::COORD_W-1:0] out_point_second,
  output logic        [rms_pkg::VALUE_W-1:0] out_point_value,
  output logic        [rms_pkg::VALUE_W-1:0] out_best_value,
  output logic signed [rms_pkg::COORD_W-1:0] out_best_first,
  output logic signed [rms_pkg::COORD_W-1:0] out_best_second
);

  localparam int CW       = rms_pkg::COORD_W;
  localparam int VW       = rms_pkg::VALUE_W;
  localparam int PW       = CW + 2;
  localparam int SUM_W    = VW + 2;
  localparam int Z_W      = VW + rms_pkg::INV_W;
  localparam int COS_DEPTH = 1 << COS_TABLE_BITS;
  localparam int EXP_DEPTH = 1 << EXP_TABLE_BITS;
  localparam logic [VW-1:0] START_VALUE = rms_pkg::objective_init(
      longint'(rms_pkg::RANGE_LOW_RESET), longint'(rms_pkg::SECOND_LOW), COS_TABLE_BITS);

  typedef logic [COS_DEPTH-1:0][rms_pkg::COS_W-1:0] cos_rom_t;
  typedef logic [EXP_DEPTH-1:0][rms_pkg::PROB_W-1:0] exp_rom_t;

  function automatic cos_rom_t build_cos();
    cos_rom_t r;
    for (int i = 0; i < COS_DEPTH; i++) r[i] = rms_pkg::cos_entry(i, COS_TABLE_BITS);
    return r;
  endfunction

  function automatic exp_rom_t build_exp();
    exp_rom_t r;
    for (int i = 0; i < EXP_DEPTH; i++) r[i] = rms_pkg::exp_entry(i, EXP_TABLE_BITS);
    return r;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos();
  localparam exp_rom_t EXP_ROM = build_exp();

  logic signed [CW-1:0] range_low, range_high;
  logic [rms_pkg::STEP_W-1:0] step_size;
  logic [rms_pkg::INV_W-1:0]  inv_temperature;

  logic signed [CW-1:0] cur_first, cur_second, low_first, low_second;
  logic [VW-1:0]        cur_value, low_value;
  logic signed [PW-1:0] px, py;
  logic                 restart, bad, acc, dpos;
  logic [rms_pkg::UNI_W-1:0] uniform;
  logic signed [SUM_W-1:0] sum;
  logic [VW-1:0]        nv;
  logic [Z_W-1:0]       z;
  logic signed [rms_pkg::COS_W-1:0] cos_q;
  logic [rms_pkg::PROB_W-1:0] exp_q;

  logic signed [PW-1:0] d1, d2, p1, p2;
  logic                 bad_now;
  logic signed [CW-1:0] sq_in;
  logic signed [2*CW-1:0] sq_prod;
  logic signed [SUM_W-1:0] sq_term, cos_term;
  logic [COS_TABLE_BITS-1:0] cos_addr;
  logic [CW-1:0]        phase;
  logic signed [VW:0]   delta;
  logic [rms_pkg::PROB_W-1:0] prob;
  logic                 exp_over;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low       <= rms_pkg::RANGE_LOW_RESET;
      range_high      <= rms_pkg::RANGE_HIGH_RESET;
      step_size       <= rms_pkg::STEP_RESET;
      inv_temperature <= rms_pkg::INV_TEMP_RESET;
    end else if (cfg_we) begin
      unique case (rms_pkg::cfg_reg_t'(cfg_index))
        rms_pkg::REG_RANGE_LOW:  range_low       <= cfg_data;
        rms_pkg::REG_RANGE_HIGH: range_high      <= cfg_data;
        rms_pkg::REG_STEP_SIZE:  step_size       <= cfg_data[rms_pkg::STEP_W-1:0];
        rms_pkg::REG_INV_TEMP:   inv_temperature <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [PW-1:0] move_of(input logic [1:0] code,
                                                   input logic [rms_pkg::STEP_W-1:0] st);
    case (code)
      rms_pkg::MOVE_MINUS: return -PW'(signed'({1'b0, st}));
      rms_pkg::MOVE_PLUS:  return PW'(signed'({1'b0, st}));
      default:             return '0;
    endcase
  endfunction

  always_comb begin
    d1 = move_of(in_move_first, step_size);
    d2 = move_of(in_move_second, step_size);
    p1 = PW'(cur_first) + d1;
    p2 = PW'(cur_second) + d2;
    bad_now = (p1 < PW'(range_low)) || (p1 > PW'(range_high)) ||
              (p2 < PW'(rms_pkg::SECOND_LOW)) || (p2 > PW'(rms_pkg::SECOND_HIGH));
  end

  // square and cosine address of the coordinate in work
  always_comb begin
    sq_in    = cmd.sq_x ? px[CW-1:0] : py[CW-1:0];
    sq_prod  = sq_in * sq_in;
    sq_term  = SUM_W'((sq_prod + 32'sd2048) >>> 12);
    phase    = {sq_in[11:0], 4'b0000};
    cos_addr = phase[CW-1 -: COS_TABLE_BITS];
    cos_term = SUM_W'(cos_q) * SUM_W'(10);
    delta    = signed'({1'b0, nv}) - signed'({1'b0, cur_value});
    exp_over = |z[Z_W-1:28];
    prob     = !dpos ? rms_pkg::PROB_ONE : (exp_over ? '0 : exp_q);
  end

  always_ff @(posedge clk) begin
    cos_q <= signed'(COS_ROM[cos_addr]);
    exp_q <= EXP_ROM[z[27 -: EXP_TABLE_BITS]];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      restart <= (in_operation == rms_pkg::OP_RESTART);
      uniform <= in_uniform;
      acc     <= 1'b0;
      if (in_operation == rms_pkg::OP_RESTART) begin
        px  <= PW'(range_low);
        py  <= PW'(rms_pkg::SECOND_LOW);
        bad <= 1'b0;
      end else begin
        px  <= p1;
        py  <= p2;
        bad <= bad_now;
      end
    end
    if (cmd.sq_x) sum <= SUM_W'(81920) + sq_term;
    if (cmd.sq_y) sum <= sum + sq_term - cos_term;
    if (cmd.cos_y) sum <= sum - cos_term;
    if (cmd.clamp) begin
      if (sum < 0) nv <= '0;
      else if (sum > SUM_W'(rms_pkg::VALUE_MAX)) nv <= rms_pkg::VALUE_MAX;
      else nv <= sum[VW-1:0];
    end
    if (cmd.mul) begin
      dpos <= delta > 0;
      z    <= delta[VW-1:0] * inv_temperature;
    end
    if (cmd.dec) acc <= {1'b0, uniform} <= prob;
  end

  // point and best state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_first  <= rms_pkg::RANGE_LOW_RESET;
      cur_second <= rms_pkg::SECOND_LOW;
      cur_value  <= START_VALUE;
      low_value  <= rms_pkg::LOW_VALUE_RESET;
      low_first  <= '0;
      low_second <= '0;
    end else begin
      if (cmd.start && (cur_value < low_value)) begin
        low_value  <= cur_value;
        low_first  <= cur_first;
        low_second <= cur_second;
      end
      if (cmd.commit && (restart || (!bad && acc))) begin
        cur_first  <= px[CW-1:0];
        cur_second <= py[CW-1:0];
        cur_value  <= nv;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_accepted    <= !restart && !bad && acc;
      out_invalid     <= !restart && bad;
      out_best_value  <= low_value;
      out_best_first  <= low_first;
      out_best_second <= low_second;
      if (restart || (!bad && acc)) begin
        out_point_first  <= px[CW-1:0];
        out_point_second <= py[CW-1:0];
        out_point_value  <= nv;
      end else begin
        out_point_first  <= cur_first;
        out_point_second <= cur_second;
        out_point_value  <= cur_value;
      end
    end
  end

  assign status.restart   = restart;
  assign status.bad       = bad;
  assign status.slot_free = !out_valid || out_ready;

  a_invalid_not_accepted: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_invalid |-> !out_accepted)
    else $error("invalid proposal reported as accepted");

  a_best_never_rises: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> low_value <= $past(low_value))
    else $error("best value increased");

  a_second_in_box: assert property (@(posedge clk) disable iff (rst)
    cur_second >= rms_pkg::SECOND_LOW && cur_second <= rms_pkg::SECOND_HIGH)
    else $error("second coordinate left the box");

endmodule

FILE: rtl/rastrigin_metropolis_step_top.sv
// ----------------------------------------------------------------------------
// rastrigin_metropolis_step_top
// One fixed-temperature metropolis step on the 2-d rastrigin function
// ----------------------------------------------------------------------------
// result path: an in-box step runs every sequencer state, an out-of-box proposal
//   goes from the x square straight to done, a restart skips multiply, exponent, decide
// throughput: one item at a time, the sequencer walks the shared square,
//   cosine table and exponent table in turn; next item taken once back in idle
// reset: synchronous, loads register defaults and the start point, no sweep
module rastrigin_metropolis_step_top #(
  parameter int COS_TABLE_BITS = rms_pkg::COS_TABLE_BITS_DEF,
  parameter int EXP_TABLE_BITS = rms_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rms_pkg::IDX_W-1:0] cfg_index,
  input  logic [rms_pkg::CFG_W-1:0] cfg_data,
  rms_in_if.sink                    in_ch,
  rms_out_if.source                 out_ch
);

  rms_pkg::cmd_t    cmd;
  rms_pkg::status_t status;

  rms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rms_datapath #(
    .COS_TABLE_BITS (COS_TABLE_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (in_ch.operation),
    .in_move_first    (in_ch.move_first),
    .in_move_second   (in_ch.move_second),
    .in_uniform       (in_ch.uniform),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_accepted     (out_ch.accepted),
    .out_invalid      (out_ch.proposal_invalid),
    .out_point_first  (out_ch.point_first),
    .out_point_second (out_ch.point_second),
    .out_point_value  (out_ch.point_value),
    .out_best_value   (out_ch.best_value),
    .out_best_first   (out_ch.best_first),
    .out_best_second  (out_ch.best_second)
  );

endmodule
